### rtl/rsb_pkg.sv
package rsb_pkg;

  localparam int PW     = 32;
  localparam int BW     = 35;
  localparam int WW     = 7;
  localparam int ACC_W  = 72;
  localparam int ROOT_W = 36;
  localparam int REM_W  = 40;
  localparam int EXT_W  = 40;

  localparam logic [WW-1:0] WIN_MIN   = 7'd2;
  localparam logic [WW-1:0] WIN_MAX   = 7'd120;
  localparam logic [WW-1:0] WIN_RESET = 7'd20;

  localparam logic signed [EXT_W-1:0] BAND_HI = 40'sd17179869183;
  localparam logic signed [EXT_W-1:0] BAND_LO = -40'sd17179869184;

  typedef struct packed {
    logic load;
    logic addr_rst;
    logic acc_clr;
    logic acc_add_price;
    logic sq_mul;
    logic acc_add_sq;
    logic div_mean;
    logic mean_take;
    logic div_var;
    logic sqrt_go;
    logic out_load;
  } rsb_cmd_t;

  typedef struct packed {
    logic          warm;
    logic          div_busy;
    logic          sqrt_busy;
    logic [WW-1:0] win;
  } rsb_sts_t;

  function automatic logic [BW-1:0] band_sat(logic signed [EXT_W-1:0] v);
    logic signed [EXT_W-1:0] c;
    c = v;
    if (v > BAND_HI) c = BAND_HI;
    if (v < BAND_LO) c = BAND_LO;
    return c[BW-1:0];
  endfunction

endpackage

### rtl/rsb_ctrl.sv
module rsb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  rsb_pkg::rsb_sts_t sts_i,
  output rsb_pkg::rsb_cmd_t cmd_o
);
  import rsb_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHK   = 4'd1;
  localparam logic [3:0] S_SRD   = 4'd2;
  localparam logic [3:0] S_SACC  = 4'd3;
  localparam logic [3:0] S_MDIV  = 4'd4;
  localparam logic [3:0] S_MWAIT = 4'd5;
  localparam logic [3:0] S_QRD   = 4'd6;
  localparam logic [3:0] S_QMUL  = 4'd7;
  localparam logic [3:0] S_QACC  = 4'd8;
  localparam logic [3:0] S_VDIV  = 4'd9;
  localparam logic [3:0] S_VWAIT = 4'd10;
  localparam logic [3:0] S_SWAIT = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0]    state_q, state_d;
  logic [WW-1:0] cnt_q, cnt_d;
  logic          ovld_q, ovld_d;
  logic          last_elem;

  assign last_elem   = (cnt_q == sts_i.win - 7'd1);
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ovld_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    ovld_d  = ovld_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHK;
        end
      end
      S_CHK: begin
        if (sts_i.warm) begin
          state_d = S_OUT;
        end else begin
          cmd_o.addr_rst = 1'b1;
          cmd_o.acc_clr  = 1'b1;
          cnt_d          = '0;
          state_d        = S_SRD;
        end
      end
      S_SRD: state_d = S_SACC;
      S_SACC: begin
        cmd_o.acc_add_price = 1'b1;
        cnt_d               = cnt_q + 7'd1;
        state_d             = last_elem ? S_MDIV : S_SRD;
      end
      S_MDIV: begin
        cmd_o.div_mean = 1'b1;
        state_d        = S_MWAIT;
      end
      S_MWAIT: begin
        if (!sts_i.div_busy) begin
          cmd_o.mean_take = 1'b1;
          cmd_o.addr_rst  = 1'b1;
          cmd_o.acc_clr   = 1'b1;
          cnt_d           = '0;
          state_d         = S_QRD;
        end
      end
      S_QRD: state_d = S_QMUL;
      S_QMUL: begin
        cmd_o.sq_mul = 1'b1;
        state_d      = S_QACC;
      end
      S_QACC: begin
        cmd_o.acc_add_sq = 1'b1;
        cnt_d            = cnt_q + 7'd1;
        state_d          = last_elem ? S_VDIV : S_QRD;
      end
      S_VDIV: begin
        cmd_o.div_var = 1'b1;
        state_d       = S_VWAIT;
      end
      S_VWAIT: begin
        if (!sts_i.div_busy) begin
          cmd_o.sqrt_go = 1'b1;
          state_d       = S_SWAIT;
        end
      end
      S_SWAIT: begin
        if (!sts_i.sqrt_busy) state_d = S_OUT;
      end
      S_OUT: begin
        if (!ovld_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          ovld_d         = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovld_q  <= ovld_d;
    end
  end

endmodule

### rtl/rsb_dp.sv
module rsb_dp #(
  parameter int MAX_WINDOW = 128,
  parameter int PRICE_BITS = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [rsb_pkg::WW-1:0]   cfg_wdata_i,
  input  logic [rsb_pkg::PW-1:0]   price_i,
  input  logic                     series_start_i,
  input  rsb_pkg::rsb_cmd_t        cmd_i,
  output rsb_pkg::rsb_sts_t        sts_o,
  output logic [rsb_pkg::PW-1:0]   band_mean_o,
  output logic [rsb_pkg::BW-1:0]   upper_one_sigma_o,
  output logic [rsb_pkg::BW-1:0]   upper_two_sigma_o,
  output logic [rsb_pkg::BW-1:0]   lower_one_sigma_o,
  output logic [rsb_pkg::BW-1:0]   lower_two_sigma_o,
  output logic                     band_valid_o
);
  import rsb_pkg::*;

  localparam int AW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SW   = $clog2(MAX_WINDOW + 1);
  localparam int TOPI = (MAX_WINDOW < 120) ? MAX_WINDOW : 120;
  localparam int PB   = (PRICE_BITS < PW) ? PRICE_BITS : PW;
  localparam logic [WW-1:0] WIN_TOP   = WW'(TOPI);
  localparam logic [PW-1:0] PMASK     = PW'((64'd1 << PB) - 64'd1);
  localparam logic [AW-1:0] SLOT_LAST = AW'(MAX_WINDOW - 1);
  localparam logic [SW-1:0] SEEN_MAX  = SW'(MAX_WINDOW);
  localparam logic [6:0]    DIV_STEPS = 7'(ACC_W);
  localparam logic [5:0]    SQ_STEPS  = 6'(ROOT_W);

  logic [PW-1:0] mem [MAX_WINDOW];

  logic [WW-1:0] win_q, win_eff, w_q;
  logic [AW-1:0] slot_q, last_q, addr_q, slot_base;
  logic [SW-1:0] seen_q, seen_base, seen_nxt;
  logic          warm_q;
  logic [PW-1:0] price_q, pmasked, rdata_q, mean_q, diff;
  logic [63:0]   prod_q;
  logic [ACC_W-1:0] acc_q;

  logic [ACC_W-1:0] div_num_q;
  logic [WW-1:0]    div_rem_q, div_d_q;
  logic [6:0]       div_cnt_q;
  logic [WW:0]      div_sh;
  logic             div_ge;

  logic [ACC_W-1:0]  rad_q;
  logic [ROOT_W-1:0] root_q;
  logic [REM_W-1:0]  sq_rem_q, sq_sh, sq_trial;
  logic [5:0]        sq_cnt_q;
  logic              sq_ge;

  logic signed [EXT_W-1:0] m_ext, s_ext;

  assign pmasked   = price_i & PMASK;
  assign slot_base = series_start_i ? '0 : slot_q;
  assign seen_base = series_start_i ? '0 : seen_q;
  assign seen_nxt  = (seen_base == SEEN_MAX) ? seen_base : seen_base + 1'b1;

  always_comb begin
    win_eff = win_q;
    if (win_q < WIN_MIN) win_eff = WIN_MIN;
    if (win_q > WIN_TOP) win_eff = WIN_TOP;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= WIN_RESET;
      slot_q <= '0;
      seen_q <= '0;
      warm_q <= 1'b0;
    end else begin
      if (cfg_we_i) win_q <= cfg_wdata_i;
      if (cmd_i.load) begin
        slot_q <= (slot_base == SLOT_LAST) ? '0 : slot_base + 1'b1;
        seen_q <= seen_nxt;
        warm_q <= 32'(seen_nxt) < 32'(win_eff);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) mem[slot_base] <= pmasked;
    rdata_q <= mem[addr_q];
  end

  assign diff = (rdata_q >= mean_q) ? rdata_q - mean_q : mean_q - rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      last_q  <= slot_base;
      price_q <= pmasked;
      w_q     <= win_eff;
    end
    if (cmd_i.addr_rst) begin
      addr_q <= last_q;
    end else if (cmd_i.acc_add_price || cmd_i.acc_add_sq) begin
      addr_q <= (addr_q == '0) ? SLOT_LAST : addr_q - 1'b1;
    end
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc_add_price) begin
      acc_q <= acc_q + ACC_W'(rdata_q);
    end else if (cmd_i.acc_add_sq) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    if (cmd_i.sq_mul) prod_q <= diff * diff;
    if (cmd_i.mean_take) mean_q <= div_num_q[PW-1:0];
  end

  // Restoring divider by a 7-bit divisor, one quotient bit per cycle.
  assign div_sh = {div_rem_q, div_num_q[ACC_W-1]};
  assign div_ge = (div_sh >= {1'b0, div_d_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_mean || cmd_i.div_var) begin
      div_cnt_q <= DIV_STEPS;
    end else if (div_cnt_q != '0) begin
      div_cnt_q <= div_cnt_q - 7'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_mean || cmd_i.div_var) begin
      div_num_q <= acc_q;
      div_rem_q <= '0;
      div_d_q   <= cmd_i.div_var ? w_q - 7'd1 : w_q;
    end else if (div_cnt_q != '0) begin
      div_num_q <= {div_num_q[ACC_W-2:0], div_ge};
      div_rem_q <= div_ge ? WW'(div_sh - {1'b0, div_d_q}) : WW'(div_sh);
    end
  end

  // Digit-by-digit square root, two radicand bits per cycle.
  assign sq_sh    = {sq_rem_q[REM_W-3:0], rad_q[ACC_W-1 -: 2]};
  assign sq_trial = {2'b00, root_q, 2'b01};
  assign sq_ge    = (sq_sh >= sq_trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_cnt_q <= '0;
    end else if (cmd_i.sqrt_go) begin
      sq_cnt_q <= SQ_STEPS;
    end else if (sq_cnt_q != '0) begin
      sq_cnt_q <= sq_cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_go) begin
      rad_q    <= div_num_q;
      root_q   <= '0;
      sq_rem_q <= '0;
    end else if (sq_cnt_q != '0) begin
      rad_q    <= {rad_q[ACC_W-3:0], 2'b00};
      root_q   <= {root_q[ROOT_W-2:0], sq_ge};
      sq_rem_q <= sq_ge ? sq_sh - sq_trial : sq_sh;
    end
  end

  assign m_ext = $signed({8'd0, mean_q});
  assign s_ext = $signed({4'd0, root_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (warm_q) begin
        band_mean_o       <= price_q;
        upper_one_sigma_o <= {3'b000, price_q};
        upper_two_sigma_o <= {3'b000, price_q};
        lower_one_sigma_o <= {3'b000, price_q};
        lower_two_sigma_o <= {3'b000, price_q};
        band_valid_o      <= 1'b0;
      end else begin
        band_mean_o       <= mean_q;
        upper_one_sigma_o <= band_sat(m_ext + s_ext);
        upper_two_sigma_o <= band_sat(m_ext + (s_ext <<< 1));
        lower_one_sigma_o <= band_sat(m_ext - s_ext);
        lower_two_sigma_o <= band_sat(m_ext - (s_ext <<< 1));
        band_valid_o      <= 1'b1;
      end
    end
  end

  assign sts_o.warm      = warm_q;
  assign sts_o.div_busy  = (div_cnt_q != '0);
  assign sts_o.sqrt_busy = (sq_cnt_q != '0);
  assign sts_o.win       = w_q;

endmodule

### rtl/rolling_sigma_band.sv
// Rolling Bollinger bands over the last window_length prices.
// Input channel (in_valid_i/in_ready_o) carries one Q16.16 price per beat,
// with series_start_i set to drop all history before that price.
// Output channel (out_valid_o/out_ready_i) gives one beat per input: the
// truncated window mean, mean +/- one and two sample sigmas (saturated to
// 35 bits signed), and band_valid_o. Until a full window is held, every
// field carries the price and band_valid_o is low.
// One price is processed at a time. A warm-up price goes straight from the
// check state to the output state; a full window runs two passes over the
// ring (read and accumulate states per entry, then read, multiply and
// accumulate states per entry, through the registered memory port), two
// 72-step bit-serial divisions and a 36-step square root, and then the
// output state, after which the block is idle for the next price.
// window_length is written through cfg_we_i/cfg_wdata_i, by the user only while
// idle (the block does not enforce it); values below 2 act as 2 and above 120 as 120.
// Reset empties the history and sets the window to 20. A stalled receiver
// holds the result in the output register; the next price is still taken
// and worked on, and its result waits until the register frees up.
module rolling_sigma_band #(
  parameter int MAX_WINDOW = 128,
  parameter int PRICE_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [rsb_pkg::WW-1:0] cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [rsb_pkg::PW-1:0] price_i,
  input  logic                   series_start_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [rsb_pkg::PW-1:0] band_mean_o,
  output logic [rsb_pkg::BW-1:0] upper_one_sigma_o,
  output logic [rsb_pkg::BW-1:0] upper_two_sigma_o,
  output logic [rsb_pkg::BW-1:0] lower_one_sigma_o,
  output logic [rsb_pkg::BW-1:0] lower_two_sigma_o,
  output logic                   band_valid_o
);
  import rsb_pkg::*;

  rsb_cmd_t cmd;
  rsb_sts_t sts;

  rsb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rsb_dp #(
    .MAX_WINDOW (MAX_WINDOW),
    .PRICE_BITS (PRICE_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .price_i           (price_i),
    .series_start_i    (series_start_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .band_mean_o       (band_mean_o),
    .upper_one_sigma_o (upper_one_sigma_o),
    .upper_two_sigma_o (upper_two_sigma_o),
    .lower_one_sigma_o (lower_one_sigma_o),
    .lower_two_sigma_o (lower_two_sigma_o),
    .band_valid_o      (band_valid_o)
  );

endmodule
